// ----- rtl/raf_pkg.sv -----
// shared constants and widths for the radial alpha falloff unit
package raf_pkg;

	localparam int COORD_W      = 10;
	localparam int SIDE_REG_W   = 11;
	localparam int INV_W        = 24;
	localparam int ALPHA_W      = 8;
	localparam int FRAC_W       = 16;
	localparam int LIN_W        = FRAC_W + 1;
	localparam int SHAPE_STAGES = 5;
	localparam int MAX_SIDE_DEF = 1024;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 24;
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 8;

	localparam logic [LIN_W-1:0] UNITY = LIN_W'(65536);

	localparam logic [SIDE_REG_W-1:0] SIDE_RESET = SIDE_REG_W'(64);
	localparam logic [INV_W-1:0]      INV_RESET  = INV_W'(185363);

	localparam logic [CFG_INDEX_W-1:0] REG_SIDE_LENGTH      = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_DIAGONAL = 1'b1;

endpackage

// ----- rtl/radial_alpha_falloff_unit.sv -----
// radial alpha falloff unit: alpha byte of a square radial gradient texture per pixel
//
// One pixel coordinate word in, one alpha byte word out, at one word per clock
// sustained while the output is ready. The pipeline is one offset stage, then the
// chain of square-root cells, one root bit per cell, then five shaping stages
// (ratio multiply, linear falloff, two squarings, byte scale). Every stage holds
// its word on a stall and bubbles close up, so the input keeps being taken while
// a result waits at the output, until every stage holds a word.
// side_length is clamped to MAX_SIDE; inverse_diagonal is used as written. Registers
// are to be written only while no word is in flight; the block does not enforce it.
module radial_alpha_falloff_unit #(
	parameter int MAX_SIDE = raf_pkg::MAX_SIDE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [raf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [raf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [raf_pkg::IN_TDATA_W-1:0]     s_tdata,   // pixel_x, pixel_y, zero pad
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [raf_pkg::OUT_TDATA_W-1:0]    m_tdata    // alpha
);

	localparam int CW     = raf_pkg::COORD_W;
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int DX_W   = (SIDE_W > CW + 1) ? SIDE_W : CW + 1;
	localparam int SUM_W  = 2 * DX_W + 1;
	localparam int ROOT_W = (SUM_W + raf_pkg::FRAC_W + 1) / 2;
	localparam int OP_W   = 2 * ROOT_W;
	localparam int DEPTH  = 1 + ROOT_W + raf_pkg::SHAPE_STAGES;
	localparam int OCC_W  = $clog2(DEPTH + 1);

	logic [raf_pkg::SIDE_REG_W-1:0] side_length_q;
	logic [raf_pkg::INV_W-1:0]      inverse_diagonal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_length_q      <= raf_pkg::SIDE_RESET;
			inverse_diagonal_q <= raf_pkg::INV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				raf_pkg::REG_SIDE_LENGTH: begin
					side_length_q <= cfg_data[raf_pkg::SIDE_REG_W-1:0];
				end
				raf_pkg::REG_INVERSE_DIAGONAL: begin
					inverse_diagonal_q <= cfg_data[raf_pkg::INV_W-1:0];
				end
			endcase
		end
	end

	// offsets and squared distance
	logic [CW-1:0]    pixel_x;
	logic [CW-1:0]    pixel_y;
	logic [DX_W-1:0]  side_ext;
	logic [DX_W-1:0]  side_eff;
	logic [DX_W-1:0]  x2;
	logic [DX_W-1:0]  y2;
	logic [DX_W-1:0]  dx;
	logic [DX_W-1:0]  dy;
	logic [SUM_W-1:0] sum;

	always_comb begin
		pixel_x  = s_tdata[CW-1:0];
		pixel_y  = s_tdata[2*CW-1:CW];
		side_ext = DX_W'(side_length_q);
		side_eff = (side_ext > DX_W'(MAX_SIDE)) ? DX_W'(MAX_SIDE) : side_ext;
		x2       = DX_W'({pixel_x, 1'b0});
		y2       = DX_W'({pixel_y, 1'b0});
		dx       = (x2 >= side_eff) ? x2 - side_eff : side_eff - x2;
		dy       = (y2 >= side_eff) ? y2 - side_eff : side_eff - y2;
		sum      = SUM_W'(dx) * SUM_W'(dx) + SUM_W'(dy) * SUM_W'(dy);
	end

	logic             v_s1;
	logic [SUM_W-1:0] sum_s1;
	logic             front_ready;

	logic              v_c    [0:ROOT_W];
	logic              r_c    [0:ROOT_W];
	logic [OP_W-1:0]   op_c   [0:ROOT_W];
	logic [ROOT_W:0]   rem_c  [0:ROOT_W];
	logic [ROOT_W-1:0] root_c [0:ROOT_W];

	assign front_ready = !v_s1 || r_c[0];
	assign s_tready    = front_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (front_ready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (front_ready) begin
			sum_s1 <= sum;
		end
	end

	// square-root chain on sum scaled by 2^16
	assign v_c[0]    = v_s1;
	assign op_c[0]   = OP_W'({sum_s1, {raf_pkg::FRAC_W{1'b0}}});
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		raf_sqrt_cell #(
			.ROOT_W (ROOT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[i]),
			.in_ready  (r_c[i]),
			.in_op     (op_c[i]),
			.in_rem    (rem_c[i]),
			.in_root   (root_c[i]),
			.out_valid (v_c[i+1]),
			.out_ready (r_c[i+1]),
			.out_op    (op_c[i+1]),
			.out_rem   (rem_c[i+1]),
			.out_root  (root_c[i+1])
		);
	end

	logic [raf_pkg::ALPHA_W-1:0] alpha;

	raf_shape #(
		.ROOT_W (ROOT_W)
	) u_shape (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (v_c[ROOT_W]),
		.in_ready         (r_c[ROOT_W]),
		.root             (root_c[ROOT_W]),
		.inverse_diagonal (inverse_diagonal_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.alpha            (alpha)
	);

	assign m_tdata = alpha;

	// words in flight
	logic [OCC_W-1:0] occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({s_tvalid && s_tready, m_tvalid && m_tready})
				2'b10:   occ_q <= occ_q + OCC_W'(1);
				2'b01:   occ_q <= occ_q - OCC_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above pipeline depth");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> occ_q == OCC_W'(DEPTH))
		else $error("input stalled with a free stage");

	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("output ready did not reach the input");

	a_empty_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> !m_tvalid)
		else $error("word shown with nothing in flight");

endmodule

// ----- rtl/raf_sqrt_cell.sv -----
// one cell of the square-root chain, resolves one root bit per cell
module raf_sqrt_cell #(
	parameter int ROOT_W = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2*ROOT_W-1:0]   in_op,
	input  logic [ROOT_W:0]       in_rem,
	input  logic [ROOT_W-1:0]     in_root,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2*ROOT_W-1:0]   out_op,
	output logic [ROOT_W:0]       out_rem,
	output logic [ROOT_W-1:0]     out_root
);

	logic [ROOT_W+2:0] cur;
	logic [ROOT_W+2:0] trial;
	logic              ge;
	logic [ROOT_W:0]   nrem;
	logic [ROOT_W-1:0] nroot;

	logic                valid_q;
	logic [2*ROOT_W-1:0] op_q;
	logic [ROOT_W:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;

	always_comb begin
		cur   = {in_rem, in_op[2*ROOT_W-1 -: 2]};
		trial = {1'b0, in_root, 2'b01};
		ge    = (cur >= trial);
		nrem  = ge ? (ROOT_W+1)'(cur - trial) : (ROOT_W+1)'(cur);
		nroot = {in_root[ROOT_W-2:0], ge};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			op_q   <= {in_op[2*ROOT_W-3:0], 2'b00};
			rem_q  <= nrem;
			root_q <= nroot;
		end
	end

	assign out_valid = valid_q;
	assign out_op    = op_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;

endmodule

// ----- rtl/raf_shape.sv -----
// ratio scaling, linear falloff and fourth power shaping to the alpha byte
module raf_shape #(
	parameter int ROOT_W = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ROOT_W-1:0]              root,
	input  logic [raf_pkg::INV_W-1:0]      inverse_diagonal,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [raf_pkg::ALPHA_W-1:0]    alpha
);

	localparam int NS     = raf_pkg::SHAPE_STAGES;
	localparam int PROD_W = ROOT_W + raf_pkg::INV_W;
	localparam int RAT_W  = PROD_W - raf_pkg::FRAC_W;
	localparam int LW     = raf_pkg::LIN_W;
	localparam int SQ_W   = 2 * LW;
	localparam int SC_W   = LW + 8;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	logic [PROD_W-1:0]              prod_s1;
	logic [LW-1:0]                  lin_s2;
	logic [LW-1:0]                  sq_s3;
	logic [LW-1:0]                  quad_s4;
	logic [raf_pkg::ALPHA_W-1:0]    alpha_s5;

	logic [RAT_W-1:0] ratio;
	logic [LW-1:0]    lin;
	logic [SQ_W-1:0]  sq_full;
	logic [SQ_W-1:0]  quad_full;
	logic [SC_W-1:0]  scaled;

	always_comb begin
		en[NS-1] = !v_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	always_comb begin
		ratio     = prod_s1[PROD_W-1:raf_pkg::FRAC_W];
		lin       = (ratio >= RAT_W'(raf_pkg::UNITY)) ? '0 : LW'(RAT_W'(raf_pkg::UNITY) - ratio);
		sq_full   = SQ_W'(lin_s2) * SQ_W'(lin_s2);
		quad_full = SQ_W'(sq_s3) * SQ_W'(sq_s3);
		scaled    = (SC_W'(quad_s4) << 8) - SC_W'(quad_s4);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= PROD_W'(root) * PROD_W'(inverse_diagonal);
		end
		if (en[1]) begin
			lin_s2 <= lin;
		end
		if (en[2]) begin
			sq_s3 <= sq_full[raf_pkg::FRAC_W +: LW];
		end
		if (en[3]) begin
			quad_s4 <= quad_full[raf_pkg::FRAC_W +: LW];
		end
		if (en[4]) begin
			alpha_s5 <= scaled[raf_pkg::FRAC_W +: raf_pkg::ALPHA_W];
		end
	end

	assign out_valid = v_q[NS-1];
	assign alpha     = alpha_s5;

endmodule

// ----- test/tb.sv -----
// self-checking testbench for radial_alpha_falloff_unit with its own fixed-point alpha predictor
module tb;

	localparam int LIMIT_CYCLES = 200000;
	localparam int LATENCY      = 26;
	localparam int HOLD_LEN     = 200;
	localparam longint unsigned ONE = 64'd1 << raf_pkg::FRAC_W;

	typedef struct packed {
		logic [raf_pkg::COORD_W-1:0] py;
		logic [raf_pkg::COORD_W-1:0] px;
	} pixel_t;

	typedef struct {
		pixel_t                      pix;
		logic [raf_pkg::ALPHA_W-1:0] alpha;
	} alpha_entry_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [raf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [raf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [raf_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [raf_pkg::OUT_TDATA_W-1:0] m_tdata;

	logic [raf_pkg::SIDE_REG_W-1:0] side_q = raf_pkg::SIDE_RESET;
	logic [raf_pkg::INV_W-1:0]      inv_q  = raf_pkg::INV_RESET;

	pixel_t       pixel_q[$];
	alpha_entry_t alpha_q[$];

	logic in_fire     = 1'b0;
	logic out_fire    = 1'b0;
	bit   tx_idle_on  = 1'b1;
	bit   rx_idle_on  = 1'b1;
	bit   hold_armed  = 1'b0;
	bit   hold_taken  = 1'b0;
	int   tx_gap      = 0;
	int   rx_wait     = 0;
	int   hold_cnt    = 0;
	int   mismatch_cnt = 0;
	int   cycle_cnt   = 0;

	radial_alpha_falloff_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [raf_pkg::ALPHA_W-1:0] falloff_alpha(pixel_t p);
		longint unsigned s, x2, y2, dx, dy, root, ratio, lin, sq, quad;
		s = (side_q > raf_pkg::MAX_SIDE_DEF) ? raf_pkg::MAX_SIDE_DEF : side_q;
		x2 = longint'(p.px) * 2;
		y2 = longint'(p.py) * 2;
		dx = (x2 >= s) ? x2 - s : s - x2;
		dy = (y2 >= s) ? y2 - s : s - y2;
		root = floor_root((dx * dx + dy * dy) << raf_pkg::FRAC_W);
		ratio = (root * longint'(inv_q)) >> raf_pkg::FRAC_W;
		lin = (ratio >= ONE) ? 0 : ONE - ratio;
		sq = (lin * lin) >> raf_pkg::FRAC_W;
		quad = (sq * sq) >> raf_pkg::FRAC_W;
		return raf_pkg::ALPHA_W'((quad * 255) >> raf_pkg::FRAC_W);
	endfunction

	function automatic int unsigned inv_for(int side);
		return $rtoi(16777216.0 / (side * 1.4142135623730951) + 0.5);
	endfunction

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_fire) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					s_tdata  <= raf_pkg::IN_TDATA_W'(pixel_q.pop_front());
					s_tvalid <= 1'b1;
					tx_gap = tx_idle_on ? $urandom_range(0, 9) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				hold_cnt = HOLD_LEN;
			end
			if (out_fire)
				rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		alpha_entry_t e;
		if (!arst_n) begin
			in_fire  <= 1'b0;
			out_fire <= 1'b0;
			side_q   <= raf_pkg::SIDE_RESET;
			inv_q    <= raf_pkg::INV_RESET;
		end else begin
			in_fire  <= s_tvalid && s_tready;
			out_fire <= m_tvalid && m_tready;
			if (cfg_we) begin
				if (cfg_index == raf_pkg::REG_SIDE_LENGTH)
					side_q <= cfg_data[raf_pkg::SIDE_REG_W-1:0];
				else if (cfg_index == raf_pkg::REG_INVERSE_DIAGONAL)
					inv_q <= cfg_data[raf_pkg::INV_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				e.pix = s_tdata[2*raf_pkg::COORD_W-1:0];
				e.alpha = falloff_alpha(e.pix);
				alpha_q.push_back(e);
			end
			if (m_tvalid && m_tready) begin
				if (alpha_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected alpha word %0d", m_tdata);
				end else begin
					e = alpha_q.pop_front();
					if (m_tdata !== e.alpha) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("alpha mismatch at (%0d,%0d): expected %0d, got %0d",
								e.pix.px, e.pix.py, e.alpha, m_tdata);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [raf_pkg::CFG_INDEX_W-1:0] idx,
			input logic [raf_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// side write carries random upper bits that the register must drop
	task automatic set_shape(input int side, input int unsigned inv);
		logic [raf_pkg::CFG_DATA_W-1:0] d;
		d = raf_pkg::CFG_DATA_W'($urandom());
		d[raf_pkg::SIDE_REG_W-1:0] = raf_pkg::SIDE_REG_W'(side);
		write_reg(raf_pkg::REG_SIDE_LENGTH, d);
		write_reg(raf_pkg::REG_INVERSE_DIAGONAL, raf_pkg::CFG_DATA_W'(inv));
		@(posedge clk);
	endtask

	task automatic queue_pixel(input int x, input int y);
		pixel_t p;
		p.px = raf_pkg::COORD_W'(x);
		p.py = raf_pkg::COORD_W'(y);
		pixel_q.push_back(p);
	endtask

	// mostly inside the texture, some anywhere in the coordinate range
	task automatic queue_random(input int n, input int side);
		int lim;
		lim = (side >= 1 && side <= raf_pkg::MAX_SIDE_DEF) ? side - 1
			: (1 << raf_pkg::COORD_W) - 1;
		repeat (n) begin
			case ($urandom_range(0, 7))
				0, 1:    queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
				2:       queue_pixel(side / 2, $urandom_range(0, lim));
				default: queue_pixel($urandom_range(0, lim), $urandom_range(0, lim));
			endcase
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || s_tvalid || alpha_q.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	initial begin
		int side;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: centre, corners, far outside the texture
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(32, 32);
		queue_pixel(31, 32);
		queue_pixel(63, 63);
		queue_pixel(64, 64);
		queue_pixel(0, 1023);
		queue_pixel(1023, 0);
		queue_pixel(682, 341);
		queue_pixel(341, 682);
		queue_pixel(32, 0);
		queue_pixel(0, 32);
		queue_random(40, 64);
		wait_drained();

		set_shape(1024, inv_for(1024));
		queue_pixel(512, 512);
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(1023, 0);
		queue_random(50, 1024);
		wait_drained();

		set_shape(1, 11863284);
		queue_pixel(0, 0);
		queue_random(30, 1);
		wait_drained();

		// side beyond the maximum saturates
		set_shape(2047, inv_for(1024));
		queue_random(40, 2047);
		wait_drained();

		// zero side puts the centre at the origin
		set_shape(0, $urandom_range(1, 11863284));
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_random(30, 0);
		wait_drained();

		// zero inverse gives full alpha everywhere
		set_shape(200, 0);
		queue_random(30, 200);
		wait_drained();

		// inverse far from the side
		set_shape(512, 24'hFFFFFF);
		queue_random(30, 512);
		wait_drained();

		// long output hold-off with the sender running flat out
		set_shape(256, inv_for(256));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		queue_random(100, 256);
		do
			@(posedge clk);
		while (pixel_q.size() > 80);
		hold_armed = 1'b1;
		wait_drained();

		repeat (4) begin
			side = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 64);
			tx_idle_on = 1'($urandom_range(0, 1));
			rx_idle_on = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0)
				set_shape(side, $urandom_range(0, 24'hFFFFFF));
			else
				set_shape(side, inv_for(side));
			queue_random(40, side);
			wait_drained();
		end

		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_cnt == 0 && alpha_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
